/* rtl/tdtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Shared widths, constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package tdtc_pkg;

  localparam int unsigned TickWidthDef = 32;
  localparam int unsigned SecW         = 32;
  localparam int unsigned NsW          = 30;
  localparam int unsigned RateW        = 20;
  localparam int unsigned OpW          = 2;
  localparam int unsigned CfgAddrW     = 2;
  localparam int unsigned CfgDataW     = 32;

  localparam int unsigned LagFW    = NsW + 1;
  localparam int unsigned ProdW    = SecW + NsW;
  localparam int unsigned NsTotW   = NsW + RateW + 1;
  localparam int unsigned NsDivW   = 52;
  localparam int unsigned NsSteps  = NsDivW / 2;
  localparam int unsigned SkipSumW = SecW + RateW + 1;

  localparam logic [NsW-1:0]   NsPerSec       = 30'd1000000000;
  localparam logic [NsW-1:0]   NsMax          = 30'd999999999;
  localparam logic [RateW-1:0] RateReset      = 20'd100;
  localparam logic [NsW-1:0]   NsPerTickReset = 30'd10000000;

  typedef enum logic [OpW-1:0] {
    OP_READ = 2'd0,
    OP_SYNC = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_TICK_RATE   = 2'd0,
    CFG_NS_PER_TICK = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_CHK,
    ST_DIV_SECS,
    ST_MUL_NS,
    ST_LOAD_NS,
    ST_DIV_NS,
    ST_FIN_READ,
    ST_SYNC_CHK,
    ST_MUL_FRAC,
    ST_LOAD_FRAC,
    ST_DIV_FRAC,
    ST_FIN_SYNC,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_READ_CHK,
    DP_DIV_STEP,
    DP_READ_MUL,
    DP_READ_LOAD,
    DP_READ_FIN,
    DP_SYNC_CHK,
    DP_SYNC_MUL,
    DP_SYNC_LOAD,
    DP_SYNC_FIN,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic elapsed_zero;
    logic skip_absorbs;
    logic sync_ahead;
  } dp_status_t;

endpackage

/* rtl/tdtc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdtc_req_if #(
  parameter int unsigned TickWidth = tdtc_pkg::TickWidthDef
);
  logic                        valid;
  logic                        ready;
  logic [tdtc_pkg::OpW-1:0]    operation;
  logic [TickWidth-1:0]        tick_count;
  logic [tdtc_pkg::SecW-1:0]   ref_seconds;
  logic [tdtc_pkg::NsW-1:0]    ref_nanoseconds;

  modport source (output valid, operation, tick_count, ref_seconds, ref_nanoseconds,
                  input ready);
  modport sink   (input valid, operation, tick_count, ref_seconds, ref_nanoseconds,
                  output ready);
endinterface

interface tdtc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [tdtc_pkg::SecW-1:0] time_seconds;
  logic [tdtc_pkg::NsW-1:0]  time_nanoseconds;

  modport source (output valid, time_seconds, time_nanoseconds, input ready);
  modport sink   (input valid, time_seconds, time_nanoseconds, output ready);
endinterface

interface tdtc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tdtc_pkg::CfgAddrW-1:0] addr;
  logic [tdtc_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

/* rtl/tdtc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, two quotient bits per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module tdtc_div #(
  parameter int unsigned DivW = 64
) (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic [DivW-1:0]          dividend_i,
  input  logic [tdtc_pkg::NsW-1:0] divisor_i,
  output logic [DivW-1:0]          quotient_o,
  output logic [tdtc_pkg::NsW-1:0] remainder_o
);
  import tdtc_pkg::*;

  function automatic logic [NsW:0] div_bit(input logic [NsW-1:0] rem,
                                           input logic           din,
                                           input logic [NsW-1:0] dsr);
    logic [NsW:0] trial;
    logic [NsW:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      return {1'b1, diff[NsW-1:0]};
    end
    return {1'b0, trial[NsW-1:0]};
  endfunction

  logic [DivW-1:0] acc_q, acc_d;
  logic [NsW-1:0]  rem_q, rem_d;
  logic [NsW-1:0]  dsr_q, dsr_d;
  logic [NsW:0]    hi_res;
  logic [NsW:0]    lo_res;

  always_comb begin
    hi_res = div_bit(rem_q, acc_q[DivW-1], dsr_q);
    lo_res = div_bit(hi_res[NsW-1:0], acc_q[DivW-2], dsr_q);
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (load_i) begin
      acc_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (step_i) begin
      acc_d = {acc_q[DivW-3:0], hi_res[NsW], lo_res[NsW]};
      rem_d = lo_res[NsW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = acc_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/tdtc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock datapath
// Clock state, skip counter, shared multiplier and divider, response register.
// ----------------------------------------------------------------------------
module tdtc_datapath #(
  parameter int unsigned TickWidth = tdtc_pkg::TickWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tdtc_pkg::dp_cmd_t             cmd_i,
  output tdtc_pkg::dp_status_t          status_o,
  input  logic [TickWidth-1:0]          tick_count_i,
  input  logic [tdtc_pkg::SecW-1:0]     ref_seconds_i,
  input  logic [tdtc_pkg::NsW-1:0]      ref_nanoseconds_i,
  input  logic                          cfg_we_i,
  input  logic [tdtc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [tdtc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic [tdtc_pkg::SecW-1:0]     time_seconds_o,
  output logic [tdtc_pkg::NsW-1:0]      time_nanoseconds_o
);
  import tdtc_pkg::*;

  localparam int unsigned Steps1 = (TickWidth + 1) / 2;
  localparam int unsigned W1     = 2 * Steps1;
  localparam int unsigned DivW   = (W1 > NsDivW) ? W1 : NsDivW;
  localparam int unsigned CmpW   = (TickWidth > SecW) ? TickWidth : SecW;

  logic [RateW-1:0]     rate_q, rate_d;
  logic [NsW-1:0]       nspt_q, nspt_d;
  logic [SecW-1:0]      cs_q, cs_d;
  logic [NsW-1:0]       cns_q, cns_d;
  logic [TickWidth-1:0] last_q, last_d;
  logic [SecW-1:0]      skip_q, skip_d;

  logic [TickWidth-1:0] now_q, now_d;
  logic [SecW-1:0]      rs_q, rs_d;
  logic [NsW-1:0]       rns_q, rns_d;
  logic [SecW-1:0]      lag_s_q, lag_s_d;
  logic [LagFW-1:0]     lag_f_q, lag_f_d;
  logic [ProdW-1:0]     prod_q, prod_d;
  logic [SecW-1:0]      secs_q, secs_d;
  logic [SecW-1:0]      tsec_q, tsec_d;
  logic [NsW-1:0]       tns_q, tns_d;

  logic [TickWidth-1:0] elapsed;
  logic [CmpW-1:0]      elapsed_x;
  logic [CmpW-1:0]      skip_x;
  logic [TickWidth-1:0] elapsed_eff;
  logic [SecW-1:0]      skip_left;
  logic                 elapsed_zero;
  logic                 skip_absorbs;
  logic [RateW-1:0]     rate_eff;
  logic [NsW-1:0]       rns_sat;
  logic                 ahead;
  logic                 frac_borrow;
  logic [SecW-1:0]      lag_s;
  logic [LagFW-1:0]     lag_f;
  logic [SecW-1:0]      mul_a;
  logic [NsW-1:0]       mul_b;
  logic [ProdW-1:0]     mul_p;
  logic [NsTotW-1:0]    ns_total;
  logic [SkipSumW-1:0]  skip_sum;

  logic                 div_load;
  logic                 div_step;
  logic [DivW-1:0]      div_dividend;
  logic [NsW-1:0]       div_divisor;
  logic [DivW-1:0]      div_quo;
  logic [NsW-1:0]       div_rem;

  tdtc_div #(
    .DivW(DivW)
  ) u_div (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    elapsed      = now_q - last_q;
    elapsed_x    = CmpW'(elapsed);
    skip_x       = CmpW'(skip_q);
    elapsed_zero = (elapsed == '0);
    skip_absorbs = (skip_q != '0) && (elapsed_x < skip_x);
    elapsed_eff  = TickWidth'(elapsed_x - skip_x);
    skip_left    = SecW'(skip_x - elapsed_x);
    rate_eff     = (rate_q == '0) ? RateW'(1) : rate_q;

    rns_sat     = (rns_q >= NsPerSec) ? NsMax : rns_q;
    ahead       = (rs_q > cs_q) || ((rs_q == cs_q) && (rns_sat >= cns_q));
    frac_borrow = (cns_q < rns_sat);
    lag_s       = cs_q - rs_q - SecW'(frac_borrow);
    lag_f       = {1'b0, cns_q} + (frac_borrow ? {1'b0, NsPerSec} : LagFW'(0))
                  - {1'b0, rns_sat};

    case (cmd_i.op)
      DP_READ_MUL: begin
        mul_a = SecW'(div_rem[RateW-1:0]);
        mul_b = nspt_q;
      end
      DP_SYNC_MUL: begin
        mul_a = SecW'(lag_f_q);
        mul_b = NsW'(rate_eff);
      end
      default: begin
        mul_a = lag_s_q;
        mul_b = NsW'(rate_eff);
      end
    endcase
    mul_p = ProdW'(mul_a) * ProdW'(mul_b);

    ns_total = NsTotW'(cns_q) + NsTotW'(prod_q[NsW+RateW-1:0]);
    skip_sum = SkipSumW'(prod_q[SecW+RateW-1:0]) + SkipSumW'(div_quo[NsDivW-1:0]);
  end

  always_comb begin
    div_load     = 1'b0;
    div_step     = (cmd_i.op == DP_DIV_STEP);
    div_dividend = DivW'(elapsed_eff) << (DivW - W1);
    div_divisor  = NsW'(rate_eff);
    case (cmd_i.op)
      DP_READ_CHK: begin
        div_load = !elapsed_zero && !skip_absorbs;
      end
      DP_READ_LOAD: begin
        div_load     = 1'b1;
        div_dividend = DivW'(ns_total) << (DivW - NsDivW);
        div_divisor  = NsPerSec;
      end
      DP_SYNC_LOAD: begin
        div_load     = 1'b1;
        div_dividend = DivW'(prod_q[NsTotW-1:0]) << (DivW - NsDivW);
        div_divisor  = NsPerSec;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rate_d  = rate_q;
    nspt_d  = nspt_q;
    cs_d    = cs_q;
    cns_d   = cns_q;
    last_d  = last_q;
    skip_d  = skip_q;
    now_d   = now_q;
    rs_d    = rs_q;
    rns_d   = rns_q;
    lag_s_d = lag_s_q;
    lag_f_d = lag_f_q;
    prod_d  = prod_q;
    secs_d  = secs_q;
    tsec_d  = tsec_q;
    tns_d   = tns_q;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_TICK_RATE:   rate_d = cfg_wdata_i[RateW-1:0];
        CFG_NS_PER_TICK: nspt_d = cfg_wdata_i[NsW-1:0];
        default: begin
        end
      endcase
    end

    case (cmd_i.op)
      DP_CAPTURE: begin
        now_d = tick_count_i;
        rs_d  = ref_seconds_i;
        rns_d = ref_nanoseconds_i;
      end
      DP_READ_CHK: begin
        if (!elapsed_zero) begin
          last_d = now_q;
          skip_d = skip_absorbs ? skip_left : '0;
        end
      end
      DP_READ_MUL: begin
        secs_d = div_quo[SecW-1:0];
        prod_d = mul_p;
      end
      DP_READ_FIN: begin
        cns_d = div_rem;
        cs_d  = cs_q + secs_q + div_quo[SecW-1:0];
      end
      DP_SYNC_CHK: begin
        last_d  = now_q;
        lag_s_d = lag_s;
        lag_f_d = lag_f;
        if (ahead) begin
          cs_d   = rs_q;
          cns_d  = rns_sat;
          skip_d = '0;
        end
      end
      DP_SYNC_MUL, DP_SYNC_LOAD: begin
        prod_d = mul_p;
      end
      DP_SYNC_FIN: begin
        skip_d = (skip_sum[SkipSumW-1:SecW] != '0) ? '1 : skip_sum[SecW-1:0];
      end
      DP_RESULT: begin
        tsec_d = cs_q;
        tns_d  = cns_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
      nspt_q <= NsPerTickReset;
      cs_q   <= '0;
      cns_q  <= '0;
      last_q <= '0;
      skip_q <= '0;
    end else begin
      rate_q <= rate_d;
      nspt_q <= nspt_d;
      cs_q   <= cs_d;
      cns_q  <= cns_d;
      last_q <= last_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    rs_q    <= rs_d;
    rns_q   <= rns_d;
    lag_s_q <= lag_s_d;
    lag_f_q <= lag_f_d;
    prod_q  <= prod_d;
    secs_q  <= secs_d;
    tsec_q  <= tsec_d;
    tns_q   <= tns_d;
  end

  assign status_o.elapsed_zero = elapsed_zero;
  assign status_o.skip_absorbs = skip_absorbs;
  assign status_o.sync_ahead   = ahead;
  assign time_seconds_o        = tsec_q;
  assign time_nanoseconds_o    = tns_q;

endmodule

/* rtl/tdtc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock controller
// Sequences read and sync requests through the datapath, owns response valid.
// ----------------------------------------------------------------------------
module tdtc_ctrl #(
  parameter int unsigned TickWidth = tdtc_pkg::TickWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic [tdtc_pkg::OpW-1:0] req_operation_i,
  output logic                     req_ready_o,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  input  tdtc_pkg::dp_status_t     status_i,
  output tdtc_pkg::dp_cmd_t        cmd_o
);
  import tdtc_pkg::*;

  localparam int unsigned Steps1   = (TickWidth + 1) / 2;
  localparam int unsigned MaxSteps = (Steps1 > NsSteps) ? Steps1 : NsSteps;
  localparam int unsigned CntW     = $clog2(MaxSteps);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic            rsp_free;

  assign rsp_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          case (req_operation_i)
            OP_READ: state_d = ST_READ_CHK;
            OP_SYNC: state_d = ST_SYNC_CHK;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_READ_CHK: begin
        if (status_i.elapsed_zero || status_i.skip_absorbs) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV_SECS;
          cnt_d   = CntW'(Steps1 - 1);
        end
      end
      ST_DIV_SECS: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MUL_NS;
        end
      end
      ST_MUL_NS: begin
        state_d = ST_LOAD_NS;
      end
      ST_LOAD_NS: begin
        state_d = ST_DIV_NS;
        cnt_d   = CntW'(NsSteps - 1);
      end
      ST_DIV_NS: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN_READ;
        end
      end
      ST_FIN_READ: begin
        state_d = ST_DONE;
      end
      ST_SYNC_CHK: begin
        state_d = status_i.sync_ahead ? ST_DONE : ST_MUL_FRAC;
      end
      ST_MUL_FRAC: begin
        state_d = ST_LOAD_FRAC;
      end
      ST_LOAD_FRAC: begin
        state_d = ST_DIV_FRAC;
        cnt_d   = CntW'(NsSteps - 1);
      end
      ST_DIV_FRAC: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN_SYNC;
        end
      end
      ST_FIN_SYNC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.op    = DP_NOP;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.op = DP_CAPTURE;
        end
      end
      ST_READ_CHK:  cmd_o.op = DP_READ_CHK;
      ST_DIV_SECS:  cmd_o.op = DP_DIV_STEP;
      ST_MUL_NS:    cmd_o.op = DP_READ_MUL;
      ST_LOAD_NS:   cmd_o.op = DP_READ_LOAD;
      ST_DIV_NS:    cmd_o.op = DP_DIV_STEP;
      ST_FIN_READ:  cmd_o.op = DP_READ_FIN;
      ST_SYNC_CHK:  cmd_o.op = DP_SYNC_CHK;
      ST_MUL_FRAC:  cmd_o.op = DP_SYNC_MUL;
      ST_LOAD_FRAC: cmd_o.op = DP_SYNC_LOAD;
      ST_DIV_FRAC:  cmd_o.op = DP_DIV_STEP;
      ST_FIN_SYNC:  cmd_o.op = DP_SYNC_FIN;
      ST_DONE: begin
        if (rsp_free) begin
          cmd_o.op    = DP_RESULT;
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

/* rtl/tick_driven_time_of_day_clock_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick-driven time-of-day clock
// Seconds/nanoseconds clock advanced from a free-running tick counter.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: read (advance from tick_count), sync (load or
//   slew toward ref_seconds/ref_nanoseconds) or peek. rsp_o returns the clock
//   after every request, one response per request, in order. cfg_i writes
//   tick_rate (addr 0) and ns_per_tick (addr 1) and is always ready; the user
//   writes it only while no request is in flight, not enforced by the block.
// Steps, accept to response valid (divider: two quotient bits per cycle):
//   peek: capture, result; read with no elapsed ticks or ticks absorbed by a
//   skip, or sync ahead of the clock: capture, check, result; sync behind:
//   capture, check, multiply, load, division, skip update, result; full read:
//   capture, check, division, multiply, load, division, finish, result.
// Throughput: one request at a time; a new request is taken as soon as the
//   previous one has moved into the response register.
// Reset: clock, last tick and skip clear; tick_rate 100, ns_per_tick 1e7.
// Stall: a response held by rsp_o.ready keeps the next request parked in its
//   final state until the response register frees.
// ----------------------------------------------------------------------------
module tick_driven_time_of_day_clock_unit #(
  parameter int unsigned TickWidth = tdtc_pkg::TickWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdtc_req_if.sink   req_i,
  tdtc_rsp_if.source rsp_o,
  tdtc_cfg_if.sink   cfg_i
);
  import tdtc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_ready;
  logic       rsp_valid;

  tdtc_ctrl #(
    .TickWidth(TickWidth)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_i.valid),
    .req_operation_i(req_i.operation),
    .req_ready_o    (req_ready),
    .rsp_valid_o    (rsp_valid),
    .rsp_ready_i    (rsp_o.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  tdtc_datapath #(
    .TickWidth(TickWidth)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .tick_count_i      (req_i.tick_count),
    .ref_seconds_i     (req_i.ref_seconds),
    .ref_nanoseconds_i (req_i.ref_nanoseconds),
    .cfg_we_i          (cfg_i.valid),
    .cfg_addr_i        (cfg_i.addr),
    .cfg_wdata_i       (cfg_i.wdata),
    .time_seconds_o    (rsp_o.time_seconds),
    .time_nanoseconds_o(rsp_o.time_nanoseconds)
  );

  assign req_i.ready = req_ready;
  assign rsp_o.valid = rsp_valid;
  assign cfg_i.ready = 1'b1;

endmodule

/* rtl/tdtc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock checker
// Port-level checks on request/response ordering, bound to the top level.
// ----------------------------------------------------------------------------
module tdtc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [tdtc_pkg::SecW-1:0] time_seconds_i,
  input logic [tdtc_pkg::NsW-1:0]  time_nanoseconds_i
);
  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] pending_q, pending_d;

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_acc   = rsp_valid_i && rsp_ready_i;
  assign pending_d = pending_q + 2'(req_acc) - 2'(rsp_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(time_seconds_i) && $stable(time_nanoseconds_i))
    else $error("response payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request taken while previous request in flight");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 2'd0)
    else $error("response without outstanding request");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many outstanding requests");

endmodule

bind tick_driven_time_of_day_clock_unit tdtc_checker u_tdtc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .time_seconds_i    (rsp_o.time_seconds),
  .time_nanoseconds_i(rsp_o.time_nanoseconds)
);

/* tb/tdtc_time_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock checker
// Watches the request, response and register write channels, keeps its own
// copy of the clock, last tick, skip count and registers, predicts the time
// returned for every accepted request and compares it field by field with
// the responses in order. Reports the mismatch count and the number of
// responses still outstanding.
// ----------------------------------------------------------------------------
module tdtc_time_check
  import tdtc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tdtc_req_if  req_i,
  tdtc_rsp_if  rsp_i,
  tdtc_cfg_if  cfg_i,
  output int   mismatch_count_o,
  output int   pending_o
);

  localparam longint unsigned NsPerSecond = 64'(NsPerSec);
  localparam longint unsigned SecMask     = 64'hFFFF_FFFF;
  localparam longint unsigned TickMask    = (64'd1 << TickWidthDef) - 64'd1;

  typedef struct packed {
    logic [SecW-1:0] seconds;
    logic [NsW-1:0]  nanoseconds;
  } tod_t;

  longint unsigned rate_q;
  longint unsigned ns_per_tick_q;
  longint unsigned seconds_q;
  longint unsigned nanos_q;
  longint unsigned last_tick_q;
  longint unsigned skip_q;
  tod_t            expected_times[$];

  function automatic longint unsigned rate_eff();
    return (rate_q == 0) ? 64'd1 : rate_q;
  endfunction

  function automatic void advance_clock(input longint unsigned now);
    longint unsigned elapsed;
    longint unsigned secs;
    longint unsigned rem;
    longint unsigned total;
    elapsed = (now - last_tick_q) & TickMask;
    if (elapsed == 0) return;
    if (skip_q > 0) begin
      if (elapsed < skip_q) begin
        skip_q      = skip_q - elapsed;
        last_tick_q = now;
        return;
      end
      elapsed = elapsed - skip_q;
      skip_q  = 0;
    end
    last_tick_q = now;
    secs        = elapsed / rate_eff();
    rem         = elapsed % rate_eff();
    total       = nanos_q + rem * ns_per_tick_q;
    secs        = secs + total / NsPerSecond;
    nanos_q     = total % NsPerSecond;
    seconds_q   = (seconds_q + secs) & SecMask;
  endfunction

  function automatic void sync_clock(input longint unsigned now,
                                     input longint unsigned ref_sec,
                                     input longint unsigned ref_ns);
    longint unsigned rns;
    longint unsigned lag_s;
    longint unsigned lag_f;
    longint unsigned skip;
    rns = (ref_ns >= NsPerSecond) ? NsPerSecond - 1 : ref_ns;
    if (ref_sec > seconds_q || (ref_sec == seconds_q && rns >= nanos_q)) begin
      seconds_q = ref_sec;
      nanos_q   = rns;
      skip_q    = 0;
    end else begin
      lag_s = seconds_q - ref_sec;
      if (nanos_q >= rns) begin
        lag_f = nanos_q - rns;
      end else begin
        lag_s = lag_s - 1;
        lag_f = nanos_q + NsPerSecond - rns;
      end
      skip   = lag_s * rate_eff() + (lag_f * rate_eff()) / NsPerSecond;
      skip_q = (skip > SecMask) ? SecMask : skip;
    end
    last_tick_q = now;
  endfunction

  always @(posedge clk_i) begin : monitor
    tod_t want;
    if (!rst_ni) begin
      rate_q           = 64'(RateReset);
      ns_per_tick_q    = 64'(NsPerTickReset);
      seconds_q        = 0;
      nanos_q          = 0;
      last_tick_q      = 0;
      skip_q           = 0;
      mismatch_count_o = 0;
      expected_times.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_times.size() == 0) begin
          $error("response with no request outstanding: %0d s %0d ns",
                 rsp_i.time_seconds, rsp_i.time_nanoseconds);
          mismatch_count_o++;
        end else begin
          want = expected_times.pop_front();
          if (rsp_i.time_seconds !== want.seconds) begin
            $error("time_seconds: expected %0d, actual %0d",
                   want.seconds, rsp_i.time_seconds);
            mismatch_count_o++;
          end
          if (rsp_i.time_nanoseconds !== want.nanoseconds) begin
            $error("time_nanoseconds: expected %0d, actual %0d",
                   want.nanoseconds, rsp_i.time_nanoseconds);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.addr))
          CFG_TICK_RATE:   rate_q        = 64'(cfg_i.wdata[RateW-1:0]);
          CFG_NS_PER_TICK: ns_per_tick_q = 64'(cfg_i.wdata[NsW-1:0]);
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        case (op_e'(req_i.operation))
          OP_READ: advance_clock(64'(req_i.tick_count));
          OP_SYNC: sync_clock(64'(req_i.tick_count), 64'(req_i.ref_seconds),
                              64'(req_i.ref_nanoseconds));
          default: ;
        endcase
        want.seconds     = seconds_q[SecW-1:0];
        want.nanoseconds = nanos_q[NsW-1:0];
        expected_times.push_back(want);
      end
    end
    pending_o <= expected_times.size();
  end

endmodule

/* tb/tick_driven_time_of_day_clock_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day clock testbench
// Drives directed and random read, sync and peek requests through several
// register settings, with random idle cycles on both sides, long response
// stalls and no-idle stretches. The checker beside the block predicts and
// compares every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module tick_driven_time_of_day_clock_unit_tb;
  import tdtc_pkg::*;

  localparam int unsigned      IdleLimit    = 2000;
  localparam int unsigned      DrainCycles  = 60;
  localparam int unsigned      HoldCycles   = 200;
  localparam int unsigned      PhaseCount   = 8;
  localparam int unsigned      PhaseItems   = 60;
  localparam logic [OpW-1:0]   OpUnused     = 2'd3;
  localparam logic [NsW-1:0]   NsAllOnes    = '1;
  localparam longint unsigned  NsPerSecond  = 64'(NsPerSec);

  logic clk_i = 1'b0;
  logic rst_ni;

  int mismatch_count;
  int pending;
  int idle_cycles;
  int responses_seen;

  logic [TickWidthDef-1:0] cur_tick;
  int unsigned             rate_hint;
  logic [SecW-1:0]         seen_seconds;
  logic [NsW-1:0]          seen_nanos;

  tdtc_req_if req_if ();
  tdtc_rsp_if rsp_if ();
  tdtc_cfg_if cfg_if ();

  tick_driven_time_of_day_clock_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  tdtc_time_check u_time_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_if),
    .rsp_i            (rsp_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [OpW-1:0]          op,
                              input logic [TickWidthDef-1:0] tick,
                              input logic [SecW-1:0]         secs,
                              input logic [NsW-1:0]          nsec,
                              input int unsigned             gap_max);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.operation       <= op;
    req_if.tick_count      <= tick;
    req_if.ref_seconds     <= secs;
    req_if.ref_nanoseconds <= nsec;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    cur_tick = tick;
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= addr;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (addr == CFG_TICK_RATE) begin
      rate_hint = (data[RateW-1:0] == 0) ? 1 : data[RateW-1:0];
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_request(input int unsigned gap_max);
    longint unsigned   now_ns;
    longint unsigned   offset;
    longint unsigned   target;
    logic [TickWidthDef-1:0] tick;
    int unsigned       kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      case ($urandom_range(0, 9))
        0:       tick = cur_tick;
        1, 2:    tick = cur_tick + $urandom_range(1, 20);
        3:       tick = $urandom;
        default: tick = cur_tick + $urandom_range(0, 3 * rate_hint);
      endcase
      send_request(OP_READ, tick, $urandom, $urandom, gap_max);
    end else if (kind < 75) begin
      now_ns = 64'(seen_seconds) * NsPerSecond + 64'(seen_nanos);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: offset = $urandom_range(0, 2000000000);
        6, 7:             offset = $urandom_range(0, 1000);
        8:                offset = 64'($urandom) * NsPerSecond;
        default:          offset = 0;
      endcase
      if ($urandom_range(0, 1) == 1) begin
        target = now_ns + offset;
      end else begin
        target = (offset > now_ns) ? 0 : now_ns - offset;
      end
      tick = cur_tick + $urandom_range(0, rate_hint);
      send_request(OP_SYNC, tick, SecW'(target / NsPerSecond),
                   NsW'(target % NsPerSecond), gap_max);
    end else if (kind < 88) begin
      send_request(($urandom_range(0, 1) == 1) ? OP_PEEK : OpUnused,
                   $urandom, $urandom, $urandom, gap_max);
    end else begin
      send_request(OpW'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                   gap_max);
    end
  endtask

  initial begin : response_sink
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    responses_seen = 0;
    seen_seconds   = '0;
    seen_nanos     = '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (responses_seen == 100 || responses_seen == 350) begin
        gap = HoldCycles;
      end else if (responses_seen >= 200 && responses_seen < 280) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 12);
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      seen_seconds = rsp_if.time_seconds;
      seen_nanos   = rsp_if.time_nanoseconds;
      responses_seen++;
    end
  end

  initial begin : stimulus
    int unsigned rate;
    rst_ni                 <= 1'b0;
    req_if.valid           <= 1'b0;
    req_if.operation       <= OP_PEEK;
    req_if.tick_count      <= '0;
    req_if.ref_seconds     <= '0;
    req_if.ref_nanoseconds <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.addr            <= CFG_TICK_RATE;
    cfg_if.wdata           <= '0;
    cur_tick  = '0;
    rate_hint = RateReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_PEEK, 32'd0, 32'd0, 30'd0, 12);
    send_request(OP_READ, 32'd0, 32'd0, 30'd0, 12);
    send_request(OP_READ, 32'd250, 32'd0, 30'd0, 12);
    send_request(OpUnused, 32'd260, 32'd7, 30'd7, 12);
    send_request(OP_SYNC, 32'd300, 32'd10, 30'd500000000, 12);
    send_request(OP_SYNC, 32'd300, 32'd10, 30'd500000000, 12);
    send_request(OP_SYNC, 32'd400, 32'd9, 30'd0, 12);
    send_request(OP_READ, 32'd450, 32'd0, 30'd0, 12);
    send_request(OP_READ, 32'd600, 32'd0, 30'd0, 12);
    send_request(OP_SYNC, 32'd700, 32'd11, NsAllOnes, 12);
    send_request(OP_READ, 32'd701, 32'd0, 30'd0, 12);
    send_request(OP_SYNC, 32'd701, 32'd5, 30'd500000000, 12);
    send_request(OP_PEEK, 32'd702, 32'd0, 30'd0, 12);
    send_request(OP_SYNC, 32'hFFFF_FFF0, 32'hFFFF_FFFF, NsMax, 12);
    send_request(OP_READ, 32'h0000_0010, 32'd0, 30'd0, 12);
    send_request(OP_SYNC, 32'd100, 32'hFFFF_0000, 30'd0, 12);
    send_request(OP_SYNC, 32'd200, 32'd0, 30'd0, 12);
    send_request(OP_READ, 32'd199, 32'd0, 30'd0, 12);
    send_request(OP_READ, 32'd198, 32'd0, 30'd0, 12);
    send_request(OP_SYNC, 32'hFFFF_FFFF, 32'd0, NsPerSec, 12);
    send_request(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NsAllOnes, 12);
    wait_drained();

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_TICK_RATE, 32'(RateReset));
          write_reg(CFG_NS_PER_TICK, 32'(NsPerTickReset));
        end
        1: begin
          write_reg(CFG_TICK_RATE, 32'd1);
          write_reg(CFG_NS_PER_TICK, 32'd1000000000);
        end
        2: begin
          write_reg(CFG_TICK_RATE, 32'd1000000);
          write_reg(CFG_NS_PER_TICK, 32'd1000);
        end
        3: begin
          write_reg(CFG_TICK_RATE, 32'd0);
          write_reg(CFG_NS_PER_TICK, 32'd1);
        end
        4: begin
          write_reg(CFG_TICK_RATE, 32'hFFFF_FFFF);
          write_reg(CFG_NS_PER_TICK, 32'hFFFF_FFFF);
          write_reg(CfgAddrW'(2), $urandom);
          write_reg(CfgAddrW'(3), $urandom);
        end
        5: begin
          rate = $urandom_range(1, 1000000);
          write_reg(CFG_TICK_RATE, rate);
          write_reg(CFG_NS_PER_TICK, 1000000000 / rate);
        end
        6: begin
          write_reg(CFG_TICK_RATE, $urandom);
          write_reg(CFG_NS_PER_TICK, $urandom);
        end
        default: begin
          write_reg(CFG_TICK_RATE, 32'd1000);
          write_reg(CFG_NS_PER_TICK, 32'd1000000);
        end
      endcase
      for (int unsigned item = 0; item < PhaseItems; item++) begin
        random_request((phase == 2 && item < 40) ? 0 : 12);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
